### rtl/amcf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the move command framer.
package amcf_pkg;

	localparam int POS_WIDTH   = 24;
	localparam int TGT_WIDTH   = 24;
	localparam int SPM_WIDTH   = 12;
	localparam int KIND_WIDTH  = 3;
	localparam int NAXIS       = 3;
	localparam int APB_AW      = 4;

	// step count math: prod = dist * spm, steps = prod / 1000 (low 16 bits)
	localparam int PROD_WIDTH  = POS_WIDTH + SPM_WIDTH;
	localparam int U_WIDTH     = PROD_WIDTH - 3;
	localparam int NCHUNK      = (U_WIDTH + 7) / 8;
	localparam int FOLD_WIDTH  = 18;
	localparam int RECIP_SHIFT = 25;
	localparam int RECIP_WIDTH = 19;
	localparam int MUL5_WIDTH  = FOLD_WIDTH + RECIP_WIDTH;
	localparam logic [RECIP_WIDTH-1:0] RECIP_125 =
		RECIP_WIDTH'(((1 << RECIP_SHIFT) + 124) / 125);
	localparam int Q1_WIDTH    = 12;
	localparam int STEP_WIDTH  = 16;
	localparam int LOW_WIDTH   = STEP_WIDTH + 3;

	localparam int FRAME_LEN   = 10;
	localparam int MOVE_LEN    = 3 * FRAME_LEN;
	localparam int CNT_WIDTH   = 5;

	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;

	localparam logic [KIND_WIDTH-1:0] KIND_MOVE    = 3'd0;
	localparam logic [KIND_WIDTH-1:0] KIND_DRV_ON  = 3'd1;
	localparam logic [KIND_WIDTH-1:0] KIND_DRV_OFF = 3'd2;
	localparam logic [KIND_WIDTH-1:0] KIND_SPN_ON  = 3'd3;
	localparam logic [KIND_WIDTH-1:0] KIND_SPN_OFF = 3'd4;

	localparam logic [1:0] REG_X_SPM = 2'd0;
	localparam logic [1:0] REG_Y_SPM = 2'd1;
	localparam logic [1:0] REG_Z_SPM = 2'd2;

	localparam logic [SPM_WIDTH-1:0] X_SPM_RESET = 12'd80;
	localparam logic [SPM_WIDTH-1:0] Y_SPM_RESET = 12'd266;
	localparam logic [SPM_WIDTH-1:0] Z_SPM_RESET = 12'd160;

	localparam logic [7:0] CH_LBRK = 8'h5B;
	localparam logic [7:0] CH_RBRK = 8'h5D;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_2    = 8'h32;
	localparam logic [7:0] CH_3    = 8'h33;
	localparam logic [7:0] CH_4    = 8'h34;
	localparam logic [7:0] CH_7    = 8'h37;
	localparam logic [7:0] CH_8    = 8'h38;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_C    = 8'h43;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;
	typedef logic [MOVE_LEN-1:0][7:0]  move_buf_t;

	typedef struct packed {
		logic [KIND_WIDTH-1:0] kind;
		logic                  zfirst;
		logic [NAXIS-1:0]      up;
	} ctl_t;

	// 256^k mod 125, weight of byte k when folding a value mod 125
	function automatic logic [6:0] chunk_weight(input int k);
		int i;
		int w;
		w = 1;
		for (i = 0; i < k; i++)
			w = (w * 256) % 125;
		return 7'(w);
	endfunction

	// inverse of an odd number mod 2^16, Newton iteration
	function automatic logic [STEP_WIDTH-1:0] inv_mod16(input int a);
		logic [STEP_WIDTH-1:0] av;
		logic [STEP_WIDTH-1:0] x;
		av = STEP_WIDTH'(a);
		x  = av;
		for (int i = 0; i < 4; i++)
			x = x * (16'd2 - av * x);
		return x;
	endfunction

	localparam logic [STEP_WIDTH-1:0] INV_125 = inv_mod16(125);

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return CH_0 + 8'(n);
		else
			return CH_A + 8'(n - 4'd10);
	endfunction

	function automatic frame_t axis_frame(input logic up, input logic [7:0] up_ch,
			input logic [7:0] dn_ch, input logic [STEP_WIDTH-1:0] steps);
		frame_t f;
		f[0] = CH_LBRK;
		f[1] = CH_0;
		f[2] = up ? up_ch : dn_ch;
		f[3] = hex_char(steps[7:4]);
		f[4] = hex_char(steps[3:0]);
		f[5] = hex_char(steps[15:12]);
		f[6] = hex_char(steps[11:8]);
		f[7] = CH_0;
		f[8] = CH_0;
		f[9] = CH_RBRK;
		return f;
	endfunction

endpackage

### rtl/amcf_ifs.sv
`timescale 1ns / 1ps
// Stream interfaces: command input channel and framed byte output channel.
interface amcf_cmd_if;
	import amcf_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [KIND_WIDTH-1:0]        kind;
	logic signed [TGT_WIDTH-1:0]  target_x;
	logic signed [TGT_WIDTH-1:0]  target_y;
	logic signed [TGT_WIDTH-1:0]  target_z;
	modport source (output valid, kind, target_x, target_y, target_z, input ready);
	modport sink   (input valid, kind, target_x, target_y, target_z, output ready);
endinterface

interface amcf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;
	modport source (output valid, out_byte, last_byte, input ready);
	modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

### rtl/axis_move_command_framer_top.sv
`timescale 1ns / 1ps
// Move command framer: commands in, ASCII stepper frames out, APB step scaling.
//
// Usage:
//   cmd  - command channel (valid/ready). kind 0 is an absolute 3-axis move in
//          micrometres; 1/2 drivers on/off (clear positions); 3/4 spindle on/off.
//          Kinds 5..7 are swallowed with no output.
//   frm  - byte channel (valid/ready), one ASCII byte per transfer; last_byte
//          marks the final byte of a command. A move gives 30 bytes (three
//          10-byte frames), other commands give 10.
//   APB  - steps-per-mm per axis at 0x0, 0x4, 0x8; write only while idle.
// A command passes stages 1 to 7 and the frame buffer on its way to frm.
// Throughput: one byte per cycle on frm while ready is high; a move holds the
//   output for its 30 bytes, a fixed command for its 10. The seven-stage step
//   pipeline takes one command per cycle till the 30-byte frame buffer backs up.
// The step count (dist * spm / 1000) is built without a divider: byte-fold mod
//   125, a reciprocal multiply, then an exact division by 125 via its inverse
//   mod 2^16 on the low 19 bits.
// Reset clears positions, pipeline valids and the buffer byte count, and loads
//   the default scaling (80, 266, 160). A stalled receiver holds the current byte;
//   the pipeline keeps filling until every stage is full, then cmd.ready drops.
module axis_move_command_framer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [amcf_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	amcf_cmd_if.sink                      cmd,
	amcf_byte_if.source                   frm
);
	import amcf_pkg::*;

	// configuration
	logic [SPM_WIDTH-1:0] spm_q [NAXIS];
	logic                 cfg_wr;

	// pipeline valids and advance terms
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic go1, go2, go3, go4, go5, go6, go7;
	logic load_buf;
	logic cmd_xfer, frm_xfer;

	// stage registers
	logic [KIND_WIDTH-1:0]        kind_s1;
	logic signed [POS_WIDTH-1:0]  tgt_s1 [NAXIS];
	ctl_t                         ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [POS_WIDTH-1:0]         dist_s2 [NAXIS];
	logic [PROD_WIDTH-1:0]        prod_s3 [NAXIS];
	logic [FOLD_WIDTH-1:0]        fold_s4 [NAXIS];
	logic [LOW_WIDTH-1:0]         low_s4  [NAXIS];
	logic [FOLD_WIDTH-1:0]        fold_s5 [NAXIS];
	logic [LOW_WIDTH-1:0]         low_s5  [NAXIS];
	logic [Q1_WIDTH-1:0]          q1_s5   [NAXIS];
	logic [STEP_WIDTH-1:0]        w_s6    [NAXIS];
	logic [STEP_WIDTH-1:0]        steps_s7 [NAXIS];

	logic signed [POS_WIDTH-1:0]  pos_q [NAXIS];

	// combinational
	logic signed [POS_WIDTH-1:0]  tgt_c [NAXIS];
	logic [NAXIS-1:0]             up_c;
	logic [POS_WIDTH-1:0]         dist_c [NAXIS];
	logic                         kind_ok_s1;
	logic [FOLD_WIDTH-1:0]        fold_c [NAXIS];
	logic [Q1_WIDTH-1:0]          q1_c   [NAXIS];
	logic [STEP_WIDTH-1:0]        w_c    [NAXIS];
	logic [STEP_WIDTH-1:0]        steps_c [NAXIS];
	frame_t                       fx_c, fy_c, fz_c;
	move_buf_t                    frame_c;
	logic [CNT_WIDTH-1:0]         len_c;

	// output buffer
	move_buf_t                    buf_q;
	logic [CNT_WIDTH-1:0]         cnt_q;

	//--------------------------------------------------------------------
	// APB register file
	//--------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spm_q[AX_X] <= X_SPM_RESET;
			spm_q[AX_Y] <= Y_SPM_RESET;
			spm_q[AX_Z] <= Z_SPM_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_X_SPM: spm_q[AX_X] <= pwdata[SPM_WIDTH-1:0];
				REG_Y_SPM: spm_q[AX_Y] <= pwdata[SPM_WIDTH-1:0];
				REG_Z_SPM: spm_q[AX_Z] <= pwdata[SPM_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_X_SPM: prdata = 32'(spm_q[AX_X]);
			REG_Y_SPM: prdata = 32'(spm_q[AX_Y]);
			REG_Z_SPM: prdata = 32'(spm_q[AX_Z]);
			default:   prdata = '0;
		endcase
	end

	//--------------------------------------------------------------------
	// Flow control: each stage moves when the next one is empty or moving
	//--------------------------------------------------------------------
	assign frm_xfer = frm.valid && frm.ready;
	assign load_buf = (cnt_q == '0) || ((cnt_q == CNT_WIDTH'(1)) && frm.ready);
	assign go7 = v_s7 && load_buf;
	assign go6 = v_s6 && (!v_s7 || go7);
	assign go5 = v_s5 && (!v_s6 || go6);
	assign go4 = v_s4 && (!v_s5 || go5);
	assign go3 = v_s3 && (!v_s4 || go4);
	assign go2 = v_s2 && (!v_s3 || go3);
	assign go1 = v_s1 && (!v_s2 || go2);
	assign cmd.ready = !v_s1 || go1;
	assign cmd_xfer  = cmd.valid && cmd.ready;

	// unused kinds die at stage 1 without touching positions
	assign kind_ok_s1 = (kind_s1 == KIND_MOVE) || (kind_s1 == KIND_DRV_ON) ||
		(kind_s1 == KIND_DRV_OFF) || (kind_s1 == KIND_SPN_ON) ||
		(kind_s1 == KIND_SPN_OFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (cmd_xfer)
				v_s1 <= 1'b1;
			else if (go1)
				v_s1 <= 1'b0;
			if (go1)
				v_s2 <= kind_ok_s1;
			else if (go2)
				v_s2 <= 1'b0;
			if (go2)
				v_s3 <= 1'b1;
			else if (go3)
				v_s3 <= 1'b0;
			if (go3)
				v_s4 <= 1'b1;
			else if (go4)
				v_s4 <= 1'b0;
			if (go4)
				v_s5 <= 1'b1;
			else if (go5)
				v_s5 <= 1'b0;
			if (go5)
				v_s6 <= 1'b1;
			else if (go6)
				v_s6 <= 1'b0;
			if (go6)
				v_s7 <= 1'b1;
			else if (go7)
				v_s7 <= 1'b0;
		end
	end

	//--------------------------------------------------------------------
	// Stage 1: input register, targets wrapped to position width
	//--------------------------------------------------------------------
	always_comb begin
		logic signed [31:0] tx, ty, tz;
		tx = 32'(cmd.target_x);
		ty = 32'(cmd.target_y);
		tz = 32'(cmd.target_z);
		tgt_c[AX_X] = tx[POS_WIDTH-1:0];
		tgt_c[AX_Y] = ty[POS_WIDTH-1:0];
		tgt_c[AX_Z] = tz[POS_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			kind_s1 <= cmd.kind;
			tgt_s1  <= tgt_c;
		end
	end

	//--------------------------------------------------------------------
	// Stage 2: direction and distance against the tracked position
	//--------------------------------------------------------------------
	always_comb begin
		for (int a = 0; a < NAXIS; a++) begin
			up_c[a]   = tgt_s1[a] > pos_q[a];
			dist_c[a] = up_c[a] ? POS_WIDTH'(tgt_s1[a] - pos_q[a])
				: POS_WIDTH'(pos_q[a] - tgt_s1[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NAXIS; a++)
				pos_q[a] <= '0;
		end else if (go1) begin
			if (kind_s1 == KIND_MOVE) begin
				pos_q <= tgt_s1;
			end else if ((kind_s1 == KIND_DRV_ON) || (kind_s1 == KIND_DRV_OFF)) begin
				for (int a = 0; a < NAXIS; a++)
					pos_q[a] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			ctl_s2.kind   <= kind_s1;
			ctl_s2.zfirst <= tgt_s1[AX_Z] > 0;
			ctl_s2.up     <= up_c;
			dist_s2       <= dist_c;
		end
	end

	//--------------------------------------------------------------------
	// Stage 3: distance times steps per mm
	//--------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (go2) begin
			ctl_s3 <= ctl_s2;
			for (int a = 0; a < NAXIS; a++)
				prod_s3[a] <= PROD_WIDTH'(dist_s2[a]) * PROD_WIDTH'(spm_q[a]);
		end
	end

	//--------------------------------------------------------------------
	// Stage 4: fold (prod >> 3) byte-wise into a small value, same mod 125
	//--------------------------------------------------------------------
	always_comb begin
		logic [NCHUNK*8-1:0] u;
		for (int a = 0; a < NAXIS; a++) begin
			u = (NCHUNK*8)'(prod_s3[a] >> 3);
			fold_c[a] = '0;
			for (int k = 0; k < NCHUNK; k++)
				fold_c[a] = fold_c[a] + FOLD_WIDTH'(u[8*k +: 8]) *
					FOLD_WIDTH'(chunk_weight(k));
		end
	end

	always_ff @(posedge clk) begin
		if (go3) begin
			ctl_s4  <= ctl_s3;
			fold_s4 <= fold_c;
			for (int a = 0; a < NAXIS; a++)
				low_s4[a] <= prod_s3[a][LOW_WIDTH-1:0];
		end
	end

	//--------------------------------------------------------------------
	// Stage 5: fold / 125 by reciprocal
	//--------------------------------------------------------------------
	always_comb begin
		logic [MUL5_WIDTH-1:0] m;
		for (int a = 0; a < NAXIS; a++) begin
			m       = MUL5_WIDTH'(fold_s4[a]) * MUL5_WIDTH'(RECIP_125);
			q1_c[a] = m[RECIP_SHIFT +: Q1_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (go4) begin
			ctl_s5  <= ctl_s4;
			fold_s5 <= fold_s4;
			low_s5  <= low_s4;
			q1_s5   <= q1_c;
		end
	end

	//--------------------------------------------------------------------
	// Stage 6: prod mod 1000, then low bits of (prod - rem) / 8
	//--------------------------------------------------------------------
	always_comb begin
		logic [FOLD_WIDTH-1:0] rem;
		logic [9:0]            r;
		logic [LOW_WIDTH-1:0]  d;
		for (int a = 0; a < NAXIS; a++) begin
			rem    = fold_s5[a] - FOLD_WIDTH'(q1_s5[a]) * FOLD_WIDTH'(125);
			r      = {rem[6:0], low_s5[a][2:0]};
			d      = low_s5[a] - LOW_WIDTH'(r);
			w_c[a] = d[LOW_WIDTH-1:3];
		end
	end

	always_ff @(posedge clk) begin
		if (go5) begin
			ctl_s6 <= ctl_s5;
			w_s6   <= w_c;
		end
	end

	//--------------------------------------------------------------------
	// Stage 7: exact division by 125 via inverse mod 2^16
	//--------------------------------------------------------------------
	always_comb begin
		logic [2*STEP_WIDTH-1:0] p;
		for (int a = 0; a < NAXIS; a++) begin
			p          = (2*STEP_WIDTH)'(w_s6[a]) * (2*STEP_WIDTH)'(INV_125);
			steps_c[a] = p[STEP_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (go6) begin
			ctl_s7   <= ctl_s6;
			steps_s7 <= steps_c;
		end
	end

	//--------------------------------------------------------------------
	// Frame assembly into the output buffer
	//--------------------------------------------------------------------
	always_comb begin
		fx_c = axis_frame(ctl_s7.up[AX_X], CH_7, CH_8, steps_s7[AX_X]);
		fy_c = axis_frame(ctl_s7.up[AX_Y], CH_A, CH_9, steps_s7[AX_Y]);
		fz_c = axis_frame(ctl_s7.up[AX_Z], CH_C, CH_B, steps_s7[AX_Z]);
		frame_c = '0;
		len_c   = CNT_WIDTH'(FRAME_LEN);
		case (ctl_s7.kind)
			KIND_MOVE: begin
				len_c = CNT_WIDTH'(MOVE_LEN);
				if (ctl_s7.zfirst) begin
					frame_c[FRAME_LEN-1:0]             = fz_c;
					frame_c[2*FRAME_LEN-1:FRAME_LEN]   = fx_c;
					frame_c[3*FRAME_LEN-1:2*FRAME_LEN] = fy_c;
				end else begin
					frame_c[FRAME_LEN-1:0]             = fx_c;
					frame_c[2*FRAME_LEN-1:FRAME_LEN]   = fy_c;
					frame_c[3*FRAME_LEN-1:2*FRAME_LEN] = fz_c;
				end
			end
			KIND_DRV_ON:  frame_c[FRAME_LEN-1:0] = axis_frame(1'b1, CH_2, CH_2, '0);
			KIND_DRV_OFF: frame_c[FRAME_LEN-1:0] = axis_frame(1'b1, CH_1, CH_1, '0);
			KIND_SPN_ON:  frame_c[FRAME_LEN-1:0] = axis_frame(1'b1, CH_3, CH_3, '0);
			KIND_SPN_OFF: frame_c[FRAME_LEN-1:0] = axis_frame(1'b1, CH_4, CH_4, '0);
			default:      frame_c = '0;
		endcase
	end

	// byte 0 of the buffer is the one on the port; shift down per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go7) begin
			cnt_q <= len_c;
		end else if (frm_xfer) begin
			cnt_q <= cnt_q - CNT_WIDTH'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (go7)
			buf_q <= frame_c;
		else if (frm_xfer)
			buf_q <= buf_q >> 8;
	end

	assign frm.valid     = cnt_q != '0;
	assign frm.out_byte  = buf_q[0];
	assign frm.last_byte = cnt_q == CNT_WIDTH'(1);

endmodule
